// ===== rtl/core/mmn_pkg.sv =====
// Shared constants and types of the min-max normalizer.
`timescale 1ns / 1ps

package mmn_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int RECIP_FRAC_BITS = 40;
    localparam int RECIP_BITS      = RECIP_FRAC_BITS + 1;
    localparam int DIFF_BITS       = SAMPLE_BITS + 1;
    localparam int VALUE_BITS      = 16;

    // The reciprocal is multiplied in two partial products to keep each one narrow.
    localparam int LO_BITS   = 24;
    localparam int HI_BITS   = RECIP_BITS - LO_BITS;
    localparam int PLO_BITS  = SAMPLE_BITS + LO_BITS;
    localparam int PHI_BITS  = SAMPLE_BITS + HI_BITS;
    localparam int PROD_BITS = SAMPLE_BITS + RECIP_BITS;

    localparam int SHIFT_BYTE = RECIP_FRAC_BITS - 8;
    localparam int SHIFT_UNIT = RECIP_FRAC_BITS - 16;
    localparam int LIMIT_BYTE = 255;
    localparam int LIMIT_UNIT = 65535;

    localparam int DIV_CNT_BITS = $clog2(RECIP_BITS);

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

    localparam logic ACTION_MEASURE = 1'b0;
    localparam logic ACTION_CONVERT = 1'b1;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_UNIT = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          recip_load;
    } q_entry_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] min_val;
        logic signed [SAMPLE_BITS-1:0] max_val;
    } extremes_t;

    typedef struct packed {
        logic busy;
    } back_status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic {
        BK_RUN,
        BK_DIV
    } bk_state_t;

endpackage

// ===== rtl/core/mmn_in_if.sv =====
// Input channel of the min-max normalizer: valid, ready and one pixel item.
`timescale 1ns / 1ps

interface mmn_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   action;
    logic signed [mmn_pkg::SAMPLE_BITS-1:0] sample;
    logic                                   first;

    modport source (output valid, output action, output sample, output first, input ready);
    modport sink   (input valid, input action, input sample, input first, output ready);
endinterface

// ===== rtl/core/mmn_out_if.sv =====
// Output channel of the min-max normalizer: valid, ready and one scaled item.
`timescale 1ns / 1ps

interface mmn_out_if;
    logic                            valid;
    logic                            ready;
    logic [mmn_pkg::VALUE_BITS-1:0]  value;
    logic                            degenerate;

    modport source (output valid, output value, output degenerate, input ready);
    modport sink   (input valid, input value, input degenerate, output ready);
endinterface

// ===== rtl/core/min_max_normalizer.sv =====
// Top level of the min-max normalizer: front, queue, divider and back parts.
//
// Usage: items arrive on the pixel channel. A measure item (action 0) updates the
// running minimum and maximum of the signed Q16.8 samples, and a set first flag
// restarts both from its sample; it gives no result. A convert item (action 1)
// gives one result item on the scaled channel: the sample stretched to a byte
// or to an unsigned Q0.16 fraction, as the output_mode register selects, with a
// degenerate flag when the maximum equals the minimum.
// Throughput: one convert item per cycle while results are taken and the reciprocal
// is ready. Each passes the queue, the s1 and s2 registers and the output register.
// The first convert item after reset or a measure item waits while the divider builds
// the 41-bit reciprocal of the range one bit per cycle, zero if it is empty. Measure
// items are taken one per cycle, but a measure item is held off until every
// queued convert item has delivered its result. Reset clears the extremes, the
// reciprocal and the mode register. When the receiver stalls, the result waits in the
// output register, the pipeline holds, and the front still takes convert items until
// the four-entry queue fills. The user must write the mode register through cfg_we and
// cfg_wdata only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module min_max_normalizer
(
    input  logic        clk,
    input  logic        rst_n,
    mmn_in_if.sink      pixel,
    mmn_out_if.source   scaled,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    logic                                   output_mode_reg;
    mmn_pkg::back_status_t                  back_status;
    mmn_pkg::extremes_t                     extremes;
    mmn_pkg::q_entry_t                      q_entry;
    mmn_pkg::q_entry_t                      q_head;
    logic                                   q_push;
    logic                                   q_pop;
    logic                                   q_empty;
    logic                                   q_full;
    logic                                   div_start;
    logic [mmn_pkg::SAMPLE_BITS-1:0]        div_span;
    mmn_pkg::div_status_t                   div_status;
    logic [mmn_pkg::RECIP_BITS-1:0]         div_quotient;

    // The mode register: 0 selects byte output, 1 selects the unit fraction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_mode_reg <= mmn_pkg::MODE_BYTE;
        end
        else if (cfg_we)
        begin
            output_mode_reg <= cfg_wdata;
        end
    end

    mmn_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel),
        .back_status (back_status),
        .q_empty     (q_empty),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry),
        .extremes    (extremes)
    );

    mmn_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    mmn_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .span     (div_span),
        .status   (div_status),
        .quotient (div_quotient)
    );

    mmn_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .output_mode  (output_mode_reg),
        .extremes     (extremes),
        .head         (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .status       (back_status),
        .div_start    (div_start),
        .div_span     (div_span),
        .div_status   (div_status),
        .div_quotient (div_quotient),
        .scaled       (scaled)
    );

`ifndef ASSERT_OFF
    // A measure item must never overtake convert items still in flight.
    a_measure_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready && (pixel.action == mmn_pkg::ACTION_MEASURE))
        |-> (!back_status.busy && q_empty))
        else $error("measure item accepted while convert items are in flight");

    // The divider only starts on a positive range, and never while it is running.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> ((extremes.max_val > extremes.min_val) && !div_status.busy))
        else $error("divider started on an empty range or while busy");

    // The queue is never pushed while full.
    a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    // A degenerate result always carries a zero value.
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (scaled.valid && scaled.degenerate) |-> (scaled.value == '0))
        else $error("degenerate result with nonzero value");
`endif

endmodule

// ===== rtl/core/mmn_front.sv =====
// Front part: accepts items, tracks the extremes and queues convert items.
`timescale 1ns / 1ps

module mmn_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    mmn_in_if.sink                pixel,
    input  mmn_pkg::back_status_t back_status,
    input  logic                  q_empty,
    input  logic                  q_full,
    output logic                  q_push,
    output mmn_pkg::q_entry_t     q_entry,
    output mmn_pkg::extremes_t    extremes
);

    logic signed [mmn_pkg::SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [mmn_pkg::SAMPLE_BITS-1:0] max_reg, max_next;
    logic                                   recip_ready_reg, recip_ready_next;
    logic                                   accept;

    // A measure item changes the extremes, so it waits until all converts have drained.
    assign pixel.ready = (pixel.action == mmn_pkg::ACTION_CONVERT) ? !q_full
                                                                   : (!back_status.busy && q_empty);
    assign accept = pixel.valid && pixel.ready;

    assign q_push             = accept && (pixel.action == mmn_pkg::ACTION_CONVERT);
    assign q_entry.sample     = pixel.sample;
    assign q_entry.recip_load = !recip_ready_reg;

    assign extremes.min_val = min_reg;
    assign extremes.max_val = max_reg;

    always_comb
    begin
        min_next         = min_reg;
        max_next         = max_reg;
        recip_ready_next = recip_ready_reg;
        if (accept)
        begin
            if (pixel.action == mmn_pkg::ACTION_MEASURE)
            begin
                recip_ready_next = 1'b0;
                if (pixel.first)
                begin
                    min_next = pixel.sample;
                    max_next = pixel.sample;
                end
                else
                begin
                    if (pixel.sample < min_reg)
                    begin
                        min_next = pixel.sample;
                    end
                    if (pixel.sample > max_reg)
                    begin
                        max_next = pixel.sample;
                    end
                end
            end
            else
            begin
                recip_ready_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg         <= '0;
            max_reg         <= '0;
            recip_ready_reg <= 1'b0;
        end
        else
        begin
            min_reg         <= min_next;
            max_reg         <= max_next;
            recip_ready_reg <= recip_ready_next;
        end
    end

endmodule

// ===== rtl/core/mmn_queue.sv =====
// Short queue of convert items between the front and back parts.
`timescale 1ns / 1ps

module mmn_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mmn_pkg::q_entry_t push_entry,
    input  logic              pop,
    output mmn_pkg::q_entry_t head,
    output logic              empty,
    output logic              full
);

    mmn_pkg::q_entry_t                      slot_reg [mmn_pkg::QUEUE_DEPTH];
    logic [mmn_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [mmn_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [mmn_pkg::QUEUE_CNT_BITS-1:0]     count_reg, count_next;
    logic                                   do_push;
    logic                                   do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == mmn_pkg::QUEUE_CNT_BITS'(mmn_pkg::QUEUE_DEPTH));
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + mmn_pkg::QUEUE_PTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + mmn_pkg::QUEUE_PTR_BITS'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + mmn_pkg::QUEUE_CNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - mmn_pkg::QUEUE_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/mmn_div.sv =====
// Restoring divider for floor(2^RECIP_FRAC_BITS / span), one quotient bit a cycle.
`timescale 1ns / 1ps

module mmn_div
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [mmn_pkg::SAMPLE_BITS-1:0]    span,
    output mmn_pkg::div_status_t               status,
    output logic [mmn_pkg::RECIP_BITS-1:0]     quotient
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [mmn_pkg::DIV_CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [mmn_pkg::SAMPLE_BITS-1:0]     rem_reg, rem_next;
    logic [mmn_pkg::RECIP_BITS-1:0]      q_reg, q_next;
    logic [mmn_pkg::SAMPLE_BITS:0]       rem_shift;
    logic [mmn_pkg::SAMPLE_BITS:0]       rem_sub;
    logic                                last_step;

    // The dividend is a single one in its top bit, so only the first step brings in a one.
    assign rem_shift = {rem_reg, (cnt_reg == '0)};
    assign rem_sub   = rem_shift - {1'b0, span};
    assign last_step = (cnt_reg == mmn_pkg::DIV_CNT_BITS'(mmn_pkg::RECIP_BITS - 1));

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = q_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, span})
            begin
                rem_next = rem_sub[mmn_pkg::SAMPLE_BITS-1:0];
                q_next   = {q_reg[mmn_pkg::RECIP_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[mmn_pkg::SAMPLE_BITS-1:0];
                q_next   = {q_reg[mmn_pkg::RECIP_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + mmn_pkg::DIV_CNT_BITS'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

endmodule

// ===== rtl/core/mmn_back.sv =====
// Back part: reciprocal control, scaling pipeline and output register.
`timescale 1ns / 1ps

module mmn_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               output_mode,
    input  mmn_pkg::extremes_t                 extremes,
    input  mmn_pkg::q_entry_t                  head,
    input  logic                               q_empty,
    output logic                               q_pop,
    output mmn_pkg::back_status_t              status,
    output logic                               div_start,
    output logic [mmn_pkg::SAMPLE_BITS-1:0]    div_span,
    input  mmn_pkg::div_status_t               div_status,
    input  logic [mmn_pkg::RECIP_BITS-1:0]     div_quotient,
    mmn_out_if.source                          scaled
);

    localparam int S = mmn_pkg::SAMPLE_BITS;

    mmn_pkg::bk_state_t                     state_reg, state_next;
    logic [mmn_pkg::RECIP_BITS-1:0]         recip_reg, recip_next;
    logic                                   loaded_reg, loaded_next;

    logic                                   s1_valid_reg;
    logic [S-1:0]                           s1_dmag_reg;
    logic                                   s1_degen_reg;
    logic                                   s1_mode_reg;

    logic                                   s2_valid_reg;
    logic [mmn_pkg::PLO_BITS-1:0]           s2_plo_reg;
    logic [mmn_pkg::PHI_BITS-1:0]           s2_phi_reg;
    logic                                   s2_degen_reg;
    logic                                   s2_mode_reg;

    logic                                   out_valid_reg;
    logic [mmn_pkg::VALUE_BITS-1:0]         out_value_reg, out_value_next;
    logic                                   out_degen_reg;

    logic [mmn_pkg::DIFF_BITS-1:0]          span_diff;
    logic                                   span_pos;
    logic [mmn_pkg::DIFF_BITS-1:0]          d_diff;
    logic [S-1:0]                           d_mag;
    logic                                   advance;
    logic [mmn_pkg::PROD_BITS-1:0]          prod_sum;
    logic [mmn_pkg::PROD_BITS-1:0]          prod_shift;
    logic [mmn_pkg::PROD_BITS-1:0]          limit;

    assign span_diff = {extremes.max_val[S-1], extremes.max_val}
                     - {extremes.min_val[S-1], extremes.min_val};
    assign span_pos  = extremes.max_val > extremes.min_val;
    assign div_span  = span_diff[S-1:0];

    // Samples at or below the minimum scale to zero.
    assign d_diff = {head.sample[S-1], head.sample} - {extremes.min_val[S-1], extremes.min_val};
    assign d_mag  = (!d_diff[S] && (d_diff != '0)) ? d_diff[S-1:0] : '0;

    assign advance = !out_valid_reg || scaled.ready;
    assign q_pop   = advance && !q_empty && (state_reg == mmn_pkg::BK_RUN)
                     && (!head.recip_load || loaded_reg);

    assign status.busy = s1_valid_reg || s2_valid_reg || out_valid_reg
                         || (state_reg != mmn_pkg::BK_RUN);

    always_comb
    begin
        state_next  = state_reg;
        recip_next  = recip_reg;
        loaded_next = loaded_reg;
        div_start   = 1'b0;
        case (state_reg)
            mmn_pkg::BK_RUN:
            begin
                if (!q_empty && head.recip_load && !loaded_reg)
                begin
                    if (span_pos)
                    begin
                        div_start  = 1'b1;
                        state_next = mmn_pkg::BK_DIV;
                    end
                    else
                    begin
                        recip_next  = '0;
                        loaded_next = 1'b1;
                    end
                end
                else if (q_pop && head.recip_load)
                begin
                    loaded_next = 1'b0;
                end
            end
            mmn_pkg::BK_DIV:
            begin
                if (div_status.done)
                begin
                    recip_next  = div_quotient;
                    loaded_next = 1'b1;
                    state_next  = mmn_pkg::BK_RUN;
                end
            end
            default:
            begin
                state_next = mmn_pkg::BK_RUN;
            end
        endcase
    end

    // Output stage: join the partial products, scale by mode and saturate.
    always_comb
    begin
        prod_sum = (mmn_pkg::PROD_BITS'(s2_phi_reg) << mmn_pkg::LO_BITS)
                 + mmn_pkg::PROD_BITS'(s2_plo_reg);
        if (s2_mode_reg == mmn_pkg::MODE_UNIT)
        begin
            prod_shift = prod_sum >> mmn_pkg::SHIFT_UNIT;
            limit      = mmn_pkg::PROD_BITS'(mmn_pkg::LIMIT_UNIT);
        end
        else
        begin
            prod_shift = prod_sum >> mmn_pkg::SHIFT_BYTE;
            limit      = mmn_pkg::PROD_BITS'(mmn_pkg::LIMIT_BYTE);
        end
        if (s2_degen_reg)
        begin
            out_value_next = '0;
        end
        else if (prod_shift > limit)
        begin
            out_value_next = limit[mmn_pkg::VALUE_BITS-1:0];
        end
        else
        begin
            out_value_next = prod_shift[mmn_pkg::VALUE_BITS-1:0];
        end
    end

    assign scaled.valid      = out_valid_reg;
    assign scaled.value      = out_value_reg;
    assign scaled.degenerate = out_degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmn_pkg::BK_RUN;
            recip_reg     <= '0;
            loaded_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            recip_reg  <= recip_next;
            loaded_reg <= loaded_next;
            if (advance)
            begin
                s1_valid_reg  <= q_pop;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_dmag_reg   <= d_mag;
            s1_degen_reg  <= !span_pos;
            s1_mode_reg   <= output_mode;
            s2_plo_reg    <= s1_dmag_reg * recip_reg[mmn_pkg::LO_BITS-1:0];
            s2_phi_reg    <= s1_dmag_reg * recip_reg[mmn_pkg::RECIP_BITS-1:mmn_pkg::LO_BITS];
            s2_degen_reg  <= s1_degen_reg;
            s2_mode_reg   <= s1_mode_reg;
            out_value_reg <= out_value_next;
            out_degen_reg <= s2_degen_reg;
        end
    end

endmodule
